>>> sv/tcce_pkg.sv
// tcce_pkg: shared types and constants for the text console cell engine
// holds item structs, command codes and default screen geometry
// no dependencies
package tcce_pkg;

	// default screen geometry
	localparam int unsigned COLS_DEF = 80;
	localparam int unsigned ROWS_DEF = 25;

	// blank cell: character 0, attribute 7
	localparam logic [15:0] BLANK_CELL = 16'h0700;

	// command codes
	typedef enum logic [2:0] {
		MODE_WRITE   = 3'd0,
		MODE_NEWLINE = 3'd1,
		MODE_CLEAR   = 3'd2,
		MODE_READ    = 3'd3,
		MODE_DELETE  = 3'd4,
		MODE_SETPOS  = 3'd5,
		MODE_REFRESH = 3'd6,
		MODE_NOP     = 3'd7
	} mode_t;

	// input item
	typedef struct packed {
		logic [2:0]         mode;
		logic [7:0]         symbol;
		logic [3:0]         fore_color;
		logic [3:0]         back_color;
		logic               first_of_text;
		logic [6:0]         col;
		logic [4:0]         row;
		logic signed [11:0] cell_offset;
	} tcce_in_t;

	// result item
	typedef struct packed {
		logic [7:0]  read_symbol;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] hw_cursor_location;
		logic        offset_error;
	} tcce_out_t;

	// result handoff from the controller to the output register
	typedef struct packed {
		logic      load;
		tcce_out_t item;
	} tcce_res_t;

endpackage

>>> sv/tcce_cell_mem.sv
// tcce_cell_mem: single-port-write, single-port-read cell store
// one write and one registered read per cycle, read data valid in the cycle after the read
// depends on nothing
module tcce_cell_mem #(
	parameter int unsigned NCELLS = 2000,
	parameter int unsigned AW     = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [NCELLS];
	logic [15:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tcce_ctrl.sv
// tcce_ctrl: command decode, cursor registers and clearing sweep
// drives the cell store ports and hands results to the output register
// depends on tcce_pkg
module tcce_ctrl #(
	parameter int unsigned COLS = tcce_pkg::COLS_DEF,
	parameter int unsigned ROWS = tcce_pkg::ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tcce_pkg::tcce_in_t   in_item,
	input  logic                 out_free,
	output tcce_pkg::tcce_res_t  res,
	output logic                 mem_we,
	output logic [$clog2(COLS*ROWS)-1:0] mem_waddr,
	output logic [15:0]          mem_wdata,
	output logic                 mem_re,
	output logic [$clog2(COLS*ROWS)-1:0] mem_raddr,
	input  logic [15:0]          mem_rdata
);
	import tcce_pkg::*;

	localparam int unsigned NCELLS = COLS * ROWS;
	localparam int unsigned AW     = $clog2(NCELLS);
	localparam int unsigned CW     = $clog2(COLS);
	localparam int unsigned RW     = $clog2(ROWS);
	localparam int unsigned TW     = ((AW > 11) ? AW : 11) + 2;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_READ  = 3'b100
	} state_t;

	state_t          state_q, state_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic [CW-1:0]   cur_col_q, cur_col_d;
	logic [RW-1:0]   cur_row_q, cur_row_d;
	logic [AW-1:0]   hw_q, hw_d;
	tcce_out_t       pend_q, pend_d;

	logic            accept;
	logic [CW-1:0]   col_sat, pos_col;
	logic [RW-1:0]   row_sat, pos_row;
	logic [AW-1:0]   lin_cur, lin_pos;
	logic signed [TW-1:0] tgt;
	logic            tgt_ok;
	logic            err;
	tcce_out_t       res_item;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;

	// saturated position from the item, or the cursor when the item is not the first of a text
	always_comb begin
		col_sat = ({2'b00, in_item.col} > 9'(COLS - 1)) ? CW'(COLS - 1) : CW'(in_item.col);
		row_sat = ({2'b00, in_item.row} > 7'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(in_item.row);
		pos_col = in_item.first_of_text ? col_sat : cur_col_q;
		pos_row = in_item.first_of_text ? row_sat : cur_row_q;
	end

	// linear cell addresses and offset target
	always_comb begin
		lin_cur = AW'(AW'(cur_row_q) * AW'(COLS)) + AW'(cur_col_q);
		lin_pos = AW'(AW'(pos_row) * AW'(COLS)) + AW'(pos_col);
		tgt     = TW'($signed({1'b0, lin_cur})) + TW'(in_item.cell_offset);
		tgt_ok  = !tgt[TW-1] && (tgt < TW'(NCELLS));
	end

	// command execution
	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		cur_col_d = cur_col_q;
		cur_row_d = cur_row_q;
		hw_d      = hw_q;
		pend_d    = pend_q;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = BLANK_CELL;
		mem_re    = 1'b0;
		mem_raddr = tgt[AW-1:0];
		err       = 1'b0;
		res.load  = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				clr_d  = clr_q + AW'(1);
				if (clr_q == AW'(NCELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				res.load = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					res.load = 1'b1;
					case (mode_t'(in_item.mode))
						MODE_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = lin_pos;
							mem_wdata = {in_item.back_color, in_item.fore_color, in_item.symbol};
							if (pos_col == CW'(COLS - 1)) begin
								cur_col_d = '0;
								cur_row_d = (pos_row == RW'(ROWS - 1)) ? pos_row : pos_row + RW'(1);
							end else begin
								cur_col_d = pos_col + CW'(1);
								cur_row_d = pos_row;
							end
						end
						MODE_NEWLINE: begin
							cur_col_d = '0;
							if (cur_row_q == RW'(ROWS - 1)) begin
								cur_row_d = '0;
								hw_d      = '0;
								clr_d     = '0;
								state_d   = ST_CLEAR;
							end else begin
								cur_row_d = cur_row_q + RW'(1);
								hw_d      = lin_cur - AW'(cur_col_q) + AW'(COLS);
							end
						end
						MODE_CLEAR: begin
							cur_col_d = '0;
							cur_row_d = '0;
							hw_d      = '0;
							clr_d     = '0;
							state_d   = ST_CLEAR;
						end
						MODE_READ: begin
							if (tgt_ok) begin
								mem_re   = 1'b1;
								res.load = 1'b0;
								state_d  = ST_READ;
							end else begin
								err = 1'b1;
							end
						end
						MODE_DELETE: begin
							if (tgt_ok) begin
								mem_we    = 1'b1;
								mem_waddr = tgt[AW-1:0];
								if (cur_col_q == '0) begin
									if (cur_row_q != '0) begin
										cur_row_d = cur_row_q - RW'(1);
										cur_col_d = CW'(COLS - 1);
										hw_d      = lin_cur - AW'(1);
									end
								end else begin
									cur_col_d = cur_col_q - CW'(1);
									hw_d      = lin_cur - AW'(1);
								end
							end else begin
								err = 1'b1;
							end
						end
						MODE_SETPOS: begin
							cur_col_d = col_sat;
							cur_row_d = row_sat;
						end
						MODE_REFRESH: begin
							hw_d = lin_cur;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// result built from the state after the command
		res_item.read_symbol        = '0;
		res_item.cursor_col         = 7'(cur_col_d);
		res_item.cursor_row         = 5'(cur_row_d);
		res_item.hw_cursor_location = 11'(hw_d);
		res_item.offset_error       = err;
		if (accept) begin
			pend_d = res_item;
		end
		if (state_q == ST_READ) begin
			res.item             = pend_q;
			res.item.read_symbol = mem_rdata[7:0];
		end else begin
			res.item = res_item;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cur_col_q <= '0;
			cur_row_q <= '0;
			hw_q      <= '0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			hw_q      <= hw_d;
		end
	end

	// pending read result, payload only
	always_ff @(posedge clk) begin
		pend_q <= pend_d;
	end

	// checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded while output register busy");
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("item accepted during clearing sweep");
	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_IDLE))
		else $error("read wait longer than one cycle");
	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("cell store read and write in the same cycle");

endmodule

>>> sv/text_console_cell_engine.sv
// Text console cell engine: a COLS x ROWS store of 16-bit cells (character in
// the low byte, attribute in the high byte) and a cursor. Write, newline
// below the last row, set position, refresh and delete items are taken back
// to back. A read waits in a read state for the registered cell store read
// port and takes no new item until its result is loaded. Clear, and a
// newline on the last row, produce their result at once but then sweep all
// COLS*ROWS cells (2000 at 80x25), one per cycle, before the next item is
// taken. After reset the same sweep runs before the first item is accepted.
// An item is accepted only while the output register is empty or its result
// is taken in the same cycle, so a result left waiting holds off the input.
// depends on tcce_pkg, tcce_ctrl, tcce_cell_mem
module text_console_cell_engine #(
	parameter int unsigned COLS = tcce_pkg::COLS_DEF,
	parameter int unsigned ROWS = tcce_pkg::ROWS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tcce_pkg::tcce_in_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output tcce_pkg::tcce_out_t out_item
);
	import tcce_pkg::*;

	localparam int unsigned NCELLS = COLS * ROWS;
	localparam int unsigned AW     = $clog2(NCELLS);

	tcce_res_t     res;
	logic          out_free;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic          out_valid_q;
	tcce_out_t     out_item_q;

	assign out_free = !out_valid_q || out_ready;

	tcce_ctrl #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_free  (out_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	tcce_cell_mem #(
		.NCELLS (NCELLS),
		.AW     (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res.load) begin
			out_item_q <= res.item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
